// File: hw/rtl/sprite_mover_and_collision_test_top_macros.svh
// assertion macros for the sprite mover and collision test block
// used by smct_div and sprite_mover_and_collision_test_top; expects clk and rst in scope
`ifndef SPRITE_MOVER_AND_COLLISION_TEST_TOP_MACROS_SVH
`define SPRITE_MOVER_AND_COLLISION_TEST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SMCT_ASSERT_IMM(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smct assertion failed");
`define SMCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smct assertion failed");
`else
`define SMCT_ASSERT_IMM(label, ante, cons)
`define SMCT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/smct_pkg.sv
// shared constants, codes and types of the sprite mover and collision test block
// no dependencies
`timescale 1ns / 1ps
package smct_pkg;

  localparam int CoordW    = 16;
  localparam int SizeW     = 10;
  localparam int ActW      = 3;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 10;
  localparam int BoundW    = 20;
  localparam int MagW      = 17;
  localparam int ProdW     = 2 * MagW;
  localparam int AccW      = ProdW + 1;
  localparam int DividendW = 2 * CoordW;
  localparam int DivSteps  = CoordW;
  localparam int DivCntW   = $clog2(DivSteps);

  localparam logic [ActW-1:0] ActSet    = 3'd0;
  localparam logic [ActW-1:0] ActStep   = 3'd1;
  localparam logic [ActW-1:0] ActPoint  = 3'd2;
  localparam logic [ActW-1:0] ActCircle = 3'd3;
  localparam logic [ActW-1:0] ActRect   = 3'd4;

  localparam logic [CfgIdxW-1:0] RegSpriteWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSpriteHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRigidEnable  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRigidLeft    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRigidRight   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRigidTop     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegRigidBottom  = 3'd6;

  localparam logic [SizeW-1:0] SizeReset = 10'd16;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: hw/rtl/smct_if.sv
// command and result channel interfaces of the sprite mover and collision test block
// depends on smct_pkg
`timescale 1ns / 1ps
interface smct_cmd_if import smct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;
  logic [CoordW-1:0] step_width;
  logic [CoordW-1:0] radius;
  logic [CoordW-1:0] zone_width;
  logic [CoordW-1:0] zone_height;
  logic              inset_test;

  modport source (
    output valid, action, coord_x, coord_y, step_width, radius, zone_width, zone_height,
           inset_test,
    input  ready
  );
  modport sink (
    input  valid, action, coord_x, coord_y, step_width, radius, zone_width, zone_height,
           inset_test,
    output ready
  );
endinterface

interface smct_res_if import smct_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [CoordW-1:0] cur_x;
  logic [CoordW-1:0] cur_y;

  modport source (output valid, hit, cur_x, cur_y, input ready);
  modport sink (input valid, hit, cur_x, cur_y, output ready);
endinterface

// File: hw/rtl/smct_div.sv
// iterative restoring divider, one quotient bit per cycle, 16-bit quotient
// depends on smct_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sprite_mover_and_collision_test_top_macros.svh"
module smct_div import smct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DividendW-1:0] dividend,
  input  logic [CoordW-1:0]    divisor,
  output logic [CoordW-1:0]    quotient,
  output div_stat_t            stat
);

  logic [CoordW-1:0]  rem;
  logic [CoordW-1:0]  dvs;
  logic [CoordW-1:0]  quo;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic               done;
  logic [CoordW:0]    trial;
  logic               take;

  // dividend upper half is below the divisor, so the quotient fits 16 bits
  assign trial = {rem, quo[CoordW-1]};
  assign take  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[DividendW-1:CoordW];
      quo <= dividend[CoordW-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? CoordW'(trial - {1'b0, dvs}) : trial[CoordW-1:0];
      quo <= {quo[CoordW-2:0], take};
    end
  end

  assign quotient = quo;
  assign stat     = '{busy: busy, done: done};

  `SMCT_ASSERT_IMM(a_start_idle, start, !busy)
  `SMCT_ASSERT_IMM(a_rem_below, busy, rem < dvs)
  `SMCT_ASSERT_IMM(a_done_idle, done, !busy)

endmodule

// File: hw/rtl/sprite_mover_and_collision_test_top.sv
// set, unused actions and refused rigid tests go to the finish state; point and rect tests
// use the test state, circle tests the squaring states, a step that falls short the divider
// throughput: one transaction at a time; the next is taken once the result is registered,
// and a result still waiting on the output holds the finish state
// synchronous active-high reset clears the position to 0, the registers to defaults, and
// empties the result register; no clearing pass
`timescale 1ns / 1ps
`include "sprite_mover_and_collision_test_top_macros.svh"
module sprite_mover_and_collision_test_top import smct_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  smct_cmd_if.sink            cmd,
  smct_res_if.source          res,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TEST, S_CSQX, S_CSQY, S_CSQR, S_CCMP,
    S_SCHK, S_SMUL, S_SDIV, S_SWAIT, S_SAPPLY, S_FINISH
  } state_t;

  state_t state;

  logic [SizeW-1:0] sprite_width, sprite_height;
  logic             rigid_enable;
  logic [SizeW-1:0] rigid_left, rigid_right, rigid_top, rigid_bottom;

  logic [CoordW-1:0] pos_x, pos_y;

  logic [ActW-1:0]   act;
  logic [CoordW-1:0] tx, ty, sw, rad, rw, rh;
  logic              rig;

  logic signed [BoundW-1:0] x1, x2, y1, y2;
  logic signed [BoundW-1:0] bx1, bx2, by1, by2, px_s, py_s, xs, ys;
  logic                     point_hit, rect_hit;
  logic [MagW-1:0]          ddx_c, ddy_c, ddx_mag, ddy_mag;

  logic signed [MagW-1:0] dx, dy;
  logic [CoordW-1:0]      adx, ady;
  logic                   dx_neg, dy_neg, maj_x;
  logic [CoordW-1:0]      maj_mag, min_mag;

  logic [MagW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] mul_p, prod;
  logic [AccW-1:0]  acc;

  logic              div_start;
  logic [CoordW-1:0] quotient;
  div_stat_t         div_stat;

  logic              hit;
  logic              out_valid, out_hit;
  logic [CoordW-1:0] out_x, out_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= SizeReset;
      sprite_height <= SizeReset;
      rigid_enable  <= 1'b0;
      rigid_left    <= '0;
      rigid_right   <= '0;
      rigid_top     <= '0;
      rigid_bottom  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegSpriteWidth:  sprite_width  <= cfg_data;
        RegSpriteHeight: sprite_height <= cfg_data;
        RegRigidEnable:  rigid_enable  <= cfg_data[0];
        RegRigidLeft:    rigid_left    <= cfg_data;
        RegRigidRight:   rigid_right   <= cfg_data;
        RegRigidTop:     rigid_top     <= cfg_data;
        RegRigidBottom:  rigid_bottom  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sprite box bounds, upper bound exclusive
  always_comb begin
    px_s = $signed(BoundW'(pos_x));
    py_s = $signed(BoundW'(pos_y));
    if (rig) begin
      bx1 = px_s + $signed(BoundW'(rigid_left));
      by1 = py_s + $signed(BoundW'(rigid_top));
      bx2 = px_s + $signed(BoundW'(sprite_width)) - $signed(BoundW'(rigid_right));
      by2 = py_s + $signed(BoundW'(sprite_height)) - $signed(BoundW'(rigid_bottom));
    end else begin
      bx1 = px_s;
      by1 = py_s;
      bx2 = px_s + $signed(BoundW'(sprite_width));
      by2 = py_s + $signed(BoundW'(sprite_height));
    end
  end

  always_comb begin
    xs = $signed(BoundW'(tx));
    ys = $signed(BoundW'(ty));
    point_hit = (xs >= x1) && (xs < x2) && (ys >= y1) && (ys < y2);
    rect_hit  = (x1 <= xs + $signed(BoundW'(rw))) && (xs < x2) &&
                (y1 <= ys + $signed(BoundW'(rh))) && (ys < y2);
    // clamp to lower bound first, then upper
    if (xs < x1) begin
      ddx_c = MagW'(x1 - xs);
    end else if (xs > x2) begin
      ddx_c = MagW'(xs - x2);
    end else begin
      ddx_c = '0;
    end
    if (ys < y1) begin
      ddy_c = MagW'(y1 - ys);
    end else if (ys > y2) begin
      ddy_c = MagW'(ys - y2);
    end else begin
      ddy_c = '0;
    end
  end

  // step deltas
  always_comb begin
    dx  = $signed({1'b0, tx}) - $signed({1'b0, pos_x});
    dy  = $signed({1'b0, ty}) - $signed({1'b0, pos_y});
    adx = dx[MagW-1] ? CoordW'(-dx) : dx[CoordW-1:0];
    ady = dy[MagW-1] ? CoordW'(-dy) : dy[CoordW-1:0];
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CSQX: begin
        mul_a = ddx_mag;
        mul_b = ddx_mag;
      end
      S_CSQY: begin
        mul_a = ddy_mag;
        mul_b = ddy_mag;
      end
      S_CSQR: begin
        mul_a = {1'b0, rad};
        mul_b = {1'b0, rad};
      end
      S_SMUL: begin
        mul_a = {1'b0, sw};
        mul_b = {1'b0, min_mag};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = (state == S_SDIV);

  smct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[DividendW-1:0]),
    .divisor  (maj_mag),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos_x     <= '0;
      pos_y     <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act   <= cmd.action;
            tx    <= cmd.coord_x;
            ty    <= cmd.coord_y;
            sw    <= cmd.step_width;
            rad   <= cmd.radius;
            rw    <= cmd.zone_width;
            rh    <= cmd.zone_height;
            rig   <= cmd.inset_test;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          hit <= 1'b0;
          if (act == ActSet) begin
            pos_x <= tx;
            pos_y <= ty;
            state <= S_FINISH;
          end else if (act == ActStep) begin
            dx_neg  <= dx[MagW-1];
            dy_neg  <= dy[MagW-1];
            maj_x   <= adx >= ady;
            maj_mag <= (adx >= ady) ? adx : ady;
            min_mag <= (adx >= ady) ? ady : adx;
            state   <= S_SCHK;
          end else if ((act inside {ActPoint, ActCircle, ActRect}) && !(rig && !rigid_enable)) begin
            x1    <= bx1;
            x2    <= bx2;
            y1    <= by1;
            y2    <= by2;
            state <= S_TEST;
          end else begin
            state <= S_FINISH;
          end
        end
        S_TEST: begin
          if (act == ActCircle) begin
            ddx_mag <= ddx_c;
            ddy_mag <= ddy_c;
            state   <= S_CSQX;
          end else begin
            hit   <= (act == ActPoint) ? point_hit : rect_hit;
            state <= S_FINISH;
          end
        end
        S_CSQX: begin
          prod  <= mul_p;
          state <= S_CSQY;
        end
        S_CSQY: begin
          acc   <= AccW'(prod);
          prod  <= mul_p;
          state <= S_CSQR;
        end
        S_CSQR: begin
          acc   <= acc + AccW'(prod);
          prod  <= mul_p;
          state <= S_CCMP;
        end
        S_CCMP: begin
          hit   <= acc <= AccW'(prod);
          state <= S_FINISH;
        end
        S_SCHK: begin
          if (maj_mag <= sw) begin
            pos_x <= tx;
            pos_y <= ty;
            state <= S_FINISH;
          end else begin
            state <= S_SMUL;
          end
        end
        S_SMUL: begin
          prod  <= mul_p;
          state <= S_SDIV;
        end
        S_SDIV: begin
          state <= S_SWAIT;
        end
        S_SWAIT: begin
          if (div_stat.done) begin
            state <= S_SAPPLY;
          end
        end
        S_SAPPLY: begin
          if (maj_x) begin
            pos_x <= dx_neg ? pos_x - sw : pos_x + sw;
            pos_y <= dy_neg ? pos_y - quotient : pos_y + quotient;
          end else begin
            pos_y <= dy_neg ? pos_y - sw : pos_y + sw;
            pos_x <= dx_neg ? pos_x - quotient : pos_x + quotient;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || res.ready) begin
            out_valid <= 1'b1;
            out_hit   <= hit;
            out_x     <= pos_x;
            out_y     <= pos_y;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.hit   = out_hit;
  assign res.cur_x = out_x;
  assign res.cur_y = out_y;

  `SMCT_ASSERT_IMM(a_div_bound, state == S_SDIV, prod[DividendW-1:CoordW] < maj_mag)
  `SMCT_ASSERT_IMM(a_div_owner, div_stat.busy, state == S_SWAIT)
  `SMCT_ASSERT_NXT(a_pos_hold, state == S_IDLE || state == S_FINISH, $stable(pos_x) && $stable(pos_y))
  `SMCT_ASSERT_IMM(a_move_no_hit, state == S_FINISH && (act == ActSet || act == ActStep), !hit)

endmodule
